// ----- rtl/charclass_word_tokenizer_assert.svh -----
// ---------------------------------------------------------------------------
// charclass_word_tokenizer_assert.svh
// Assertion macros shared by the tokenizer RTL. All sample on clock and are
// disabled during reset.
// ---------------------------------------------------------------------------
`ifndef CHARCLASS_WORD_TOKENIZER_ASSERT_SVH
`define CHARCLASS_WORD_TOKENIZER_ASSERT_SVH

// cond must hold at every edge out of reset
`define CWT_ASSERT_ALWAYS(label, cond) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error("tokenizer invariant violated");

// cons must hold in the same cycle as ante
`define CWT_ASSERT_IMP(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("tokenizer implication violated");

// cons must hold in the cycle after ante
`define CWT_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("tokenizer next-cycle check violated");

`endif

// ----- rtl/cwt_pkg.sv -----
// ---------------------------------------------------------------------------
// cwt_pkg
// Types, constants and the class lookup used by the word tokenizer.
// ---------------------------------------------------------------------------
package cwt_pkg;

   localparam int CLASS_CODES = 128;
   localparam int MAX_WORD    = 4096;
   localparam int LEN_W       = 13;
   localparam int POS_W       = 16;
   localparam int BYTE_W      = 8;
   localparam int CSR_DATA_W  = 64;
   localparam int CSR_IDX_W   = 3;
   localparam int MAP_ROWS    = 4;

   typedef enum logic [1:0] {
      CLS_UNSET  = 2'd0,
      CLS_ALLOW  = 2'd1,
      CLS_SEP    = 2'd2,
      CLS_FORBID = 2'd3
   } class_type;

   typedef enum logic [2:0] {
      ST_WORD     = 3'd0,
      ST_DONE     = 3'd1,
      ST_FORBID   = 3'd2,
      ST_SHORT    = 3'd3,
      ST_LONG     = 3'd4,
      ST_UNTERM   = 3'd5,
      ST_INTERNAL = 3'd6
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CLASS_A    = 3'd0,
      CSR_CLASS_B    = 3'd1,
      CSR_CLASS_C    = 3'd2,
      CSR_CLASS_D    = 3'd3,
      CSR_MIN_LENGTH = 3'd4,
      CSR_MAX_LENGTH = 3'd5,
      CSR_ALLOW_END  = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic [MAP_ROWS-1:0][CSR_DATA_W-1:0] class_map;
      logic [LEN_W-1:0]                    min_length;
      logic [LEN_W-1:0]                    limit;       // effective max word length
      logic                                allow_end_word;
   } cfg_type;

   typedef struct packed {
      logic [POS_W-1:0]  word_start;
      logic [LEN_W-1:0]  word_length;
      status_type        status;
      logic [BYTE_W-1:0] bad_char;
      logic              buffer_end;
   } result_type;

   // 2-bit class of a byte; codes at or above CLASS_CODES are unset
   function automatic class_type class_of(
      input logic [MAP_ROWS-1:0][CSR_DATA_W-1:0] map,
      input logic [BYTE_W-1:0]                   b
   );
      logic [CSR_DATA_W-1:0] row;
      logic [5:0]            sh;
      row = map[b[6:5]];
      sh  = {b[4:0], 1'b0};
      if (b[7]) return CLS_UNSET;
      return class_type'(row[sh +: 2]);
   endfunction

endpackage

// ----- rtl/cwt_if.sv -----
// ---------------------------------------------------------------------------
// cwt_if
// Valid/ready channels of the tokenizer: byte input and result output.
// ---------------------------------------------------------------------------
interface cwt_req_if;
   import cwt_pkg::*;

   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] byte_value;
   logic              last_byte;

   modport source (output valid, output byte_value, output last_byte, input ready);
   modport sink   (input valid, input byte_value, input last_byte, output ready);
endinterface

interface cwt_rsp_if;
   import cwt_pkg::*;

   logic              valid;
   logic              ready;
   logic [POS_W-1:0]  word_start;
   logic [LEN_W-1:0]  word_length;
   logic [2:0]        status;
   logic [BYTE_W-1:0] bad_char;
   logic              buffer_end;

   modport source (output valid, output word_start, output word_length, output status,
                   output bad_char, output buffer_end, input ready);
   modport sink   (input valid, input word_start, input word_length, input status,
                   input bad_char, input buffer_end, output ready);
endinterface

// ----- rtl/cwt_csr.sv -----
// ---------------------------------------------------------------------------
// cwt_csr
// Configuration registers: class map rows, length bounds, end-of-buffer mode.
// ---------------------------------------------------------------------------
module cwt_csr
   import cwt_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output cfg_type               cfg
);

   logic [MAP_ROWS-1:0][CSR_DATA_W-1:0] class_map_ff;
   logic [LEN_W-1:0]                    min_length_ff;
   logic [LEN_W-1:0]                    max_length_ff;
   logic                                allow_end_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         class_map_ff  <= '0;
         min_length_ff <= '0;
         max_length_ff <= '0;
         allow_end_ff  <= 1'b0;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_CLASS_A:    class_map_ff[0] <= csr_wdata;
            CSR_CLASS_B:    class_map_ff[1] <= csr_wdata;
            CSR_CLASS_C:    class_map_ff[2] <= csr_wdata;
            CSR_CLASS_D:    class_map_ff[3] <= csr_wdata;
            CSR_MIN_LENGTH: min_length_ff   <= csr_wdata[LEN_W-1:0];
            CSR_MAX_LENGTH: max_length_ff   <= csr_wdata[LEN_W-1:0];
            CSR_ALLOW_END:  allow_end_ff    <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // zero or anything above the hard cap means the hard cap
   always_comb begin
      cfg.class_map      = class_map_ff;
      cfg.min_length     = min_length_ff;
      cfg.allow_end_word = allow_end_ff;
      if (max_length_ff == '0 || max_length_ff > LEN_W'(MAX_WORD))
         cfg.limit = LEN_W'(MAX_WORD);
      else
         cfg.limit = max_length_ff;
   end

endmodule

// ----- rtl/charclass_word_tokenizer.sv -----
// ---------------------------------------------------------------------------
// charclass_word_tokenizer
// Splits a byte stream into words by a programmable 2-bit class per code and
// reports each word's start and length, or the error that stops the buffer.
// ---------------------------------------------------------------------------
//  channel | dir | handshake     | payload
//  req_ch  | in  | valid/ready   | byte_value, last_byte
//  rsp_ch  | out | valid/ready   | word_start, word_length, status, bad_char, buffer_end
//  csr_*   | in  | csr_we        | csr_index, csr_wdata
//
//  One byte per cycle sustained unless a result is held on rsp_ch; a byte is
//  registered in the input register, then its result in the result register.
//  Bytes that produce no result pass even while the result register waits.
//  req_ch.ready drops only while a result is held and a new one is pending.
//  reset is synchronous and clears the tokenizer state and the valid flags of both registers.
// ---------------------------------------------------------------------------
`include "charclass_word_tokenizer_assert.svh"

module charclass_word_tokenizer
   import cwt_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   cwt_req_if.sink               req_ch,
   cwt_rsp_if.source             rsp_ch,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type cfg;

   cwt_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // input register
   logic              in_valid_ff;
   logic [BYTE_W-1:0] in_byte_ff;
   logic              in_last_ff;

   // tokenizer state
   logic              in_word_ff,    in_word_in;
   logic [LEN_W-1:0]  run_length_ff, run_length_in;
   logic [POS_W-1:0]  run_start_ff,  run_start_in;
   logic [POS_W-1:0]  position_ff,   position_in;
   logic              halted_ff,     halted_in;

   // result register
   logic              out_valid_ff;
   result_type        out_ff;

   result_type        res;
   logic              has_res;
   logic              err;
   logic              proceed;
   class_type         cls;
   logic [LEN_W-1:0]  len_next;
   logic [POS_W-1:0]  start_next;

   assign proceed      = in_valid_ff && (!out_valid_ff || rsp_ch.ready || !has_res);
   assign req_ch.ready = !in_valid_ff || proceed;

   always_comb begin
      in_word_in    = in_word_ff;
      run_length_in = run_length_ff;
      run_start_in  = run_start_ff;
      position_in   = position_ff;
      halted_in     = halted_ff;
      res           = '{word_start: '0, word_length: '0, status: ST_WORD,
                        bad_char: '0, buffer_end: in_last_ff};
      has_res       = 1'b0;
      err           = 1'b0;
      cls           = class_of(cfg.class_map, in_byte_ff);
      len_next      = in_word_ff ? run_length_ff + 1'b1 : LEN_W'(1);
      start_next    = in_word_ff ? run_start_ff : position_ff;

      if (!halted_ff) begin
         position_in = position_ff + 1'b1;
         case (cls)
            CLS_UNSET, CLS_FORBID: begin
               has_res             = 1'b1;
               err                 = 1'b1;
               res.word_start      = in_word_ff ? run_start_ff : position_ff;
               res.word_length     = in_word_ff ? run_length_ff : '0;
               res.status          = (cls == CLS_FORBID) ? ST_FORBID : ST_INTERNAL;
               res.bad_char        = (cls == CLS_FORBID) ? in_byte_ff : '0;
            end
            CLS_SEP: begin
               if (in_word_ff) begin
                  has_res         = 1'b1;
                  res.word_start  = run_start_ff;
                  res.word_length = run_length_ff;
                  if (cfg.min_length != '0 && run_length_ff < cfg.min_length) begin
                     res.status = ST_SHORT;
                     err        = 1'b1;
                  end
                  in_word_in    = 1'b0;
                  run_length_in = '0;
               end else if (in_last_ff) begin
                  has_res    = 1'b1;
                  res.status = ST_DONE;
               end
            end
            CLS_ALLOW: begin
               in_word_in    = 1'b1;
               run_start_in  = start_next;
               run_length_in = len_next;
               res.word_start  = start_next;
               res.word_length = len_next;
               if (len_next > cfg.limit) begin
                  has_res    = 1'b1;
                  err        = 1'b1;
                  res.status = ST_LONG;
               end else if (in_last_ff) begin
                  has_res    = 1'b1;
                  res.status = cfg.allow_end_word ? ST_WORD : ST_UNTERM;
               end
            end
            default: ;
         endcase
         if (err) halted_in = 1'b1;
      end

      // last byte always starts the next buffer from scratch
      if (in_last_ff) begin
         in_word_in    = 1'b0;
         run_length_in = '0;
         run_start_in  = '0;
         position_in   = '0;
         halted_in     = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         in_word_ff    <= 1'b0;
         run_length_ff <= '0;
         run_start_ff  <= '0;
         position_ff   <= '0;
         halted_ff     <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            in_valid_ff <= 1'b1;
            in_byte_ff  <= req_ch.byte_value;
            in_last_ff  <= req_ch.last_byte;
         end else if (proceed) begin
            in_valid_ff <= 1'b0;
         end

         if (proceed) begin
            in_word_ff    <= in_word_in;
            run_length_ff <= run_length_in;
            run_start_ff  <= run_start_in;
            position_ff   <= position_in;
            halted_ff     <= halted_in;
         end

         if (proceed && has_res) begin
            out_valid_ff <= 1'b1;
            out_ff       <= res;
         end else if (rsp_ch.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_ch.valid       = out_valid_ff;
   assign rsp_ch.word_start  = out_ff.word_start;
   assign rsp_ch.word_length = out_ff.word_length;
   assign rsp_ch.status      = out_ff.status;
   assign rsp_ch.bad_char    = out_ff.bad_char;
   assign rsp_ch.buffer_end  = out_ff.buffer_end;

   // a live word always has at least one byte and never passes the cap
   // (a too-long word stays open at cap + 1 while the buffer is halted)
   `CWT_ASSERT_IMP(a_run_nonzero, in_word_ff && !halted_ff, run_length_ff != '0 && run_length_ff <= cfg.limit)
   // the last byte of a buffer leaves clean state behind
   `CWT_ASSERT_NEXT(a_last_clears, proceed && in_last_ff,
                    !in_word_ff && !halted_ff && position_ff == '0)
   // a completed word result always carries at least one byte
   `CWT_ASSERT_IMP(a_word_len, out_valid_ff && out_ff.status == ST_WORD,
                   out_ff.word_length != '0)
   // a held result is never overwritten while the sink stalls
   `CWT_ASSERT_NEXT(a_no_overwrite, out_valid_ff && !rsp_ch.ready,
                    out_valid_ff && $stable(out_ff))

endmodule

// ----- bench/charclass_word_tokenizer_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// charclass_word_tokenizer_tb
// Self-checking bench for the class-table word tokenizer. Byte streams are
// pushed through the request channel in random bursts while the result
// channel stalls on its own pattern. A local tokenizer model predicts every
// result, and each result is checked in order. The run covers directed
// corner cases, one long word with no explicit limit, and random buffers
// under several class tables and length limits.
// ----------------------------------------------------------------------------
module charclass_word_tokenizer_tb;
   import cwt_pkg::*;

   localparam int STALL_LIMIT  = 2000;
   localparam int HOLD_CYCLES  = 90;
   localparam int RANDOM_BYTES = 170;

   typedef struct packed {
      logic [7:0] value;
      logic       last;
   } text_byte_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                  csr_we    = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = CSR_CLASS_A;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   cwt_req_if req_ch();
   cwt_rsp_if rsp_ch();

   charclass_word_tokenizer dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // model copy of the registers
   logic [63:0] map_rows [4] = '{default: '0};
   logic [12:0] min_word     = '0;
   logic [12:0] max_word     = '0;
   logic        end_closes   = 1'b0;

   // model tokenizer state
   logic        word_open = 1'b0;
   logic [12:0] run_len   = '0;
   logic [15:0] run_from  = '0;
   logic [15:0] byte_pos  = '0;
   logic        stopped   = 1'b0;

   text_byte_type pending_bytes [$];
   result_type expected_results [$];

   logic [63:0] plan_map [4];
   int  bytes_queued = 0;
   int  bytes_seen   = 0;
   int  results_seen = 0;
   int  mismatches   = 0;
   int  status_count [8] = '{default: 0};
   int  idle_cycles  = 0;
   bit  byte_taken   = 1'b0;
   int  burst_left   = 1;
   int  gap_left     = 0;
   int  rcv_cycle    = 0;
   int  hold_left    = 0;
   int  hold_asks    = 0;
   int  hold_served  = 0;
   result_type want, got;

   function automatic class_type code_class(input logic [7:0] b);
      if (b[7]) return CLS_UNSET;
      return class_type'(map_rows[b[6:5]][2*b[4:0] +: 2]);
   endfunction

   function automatic void restart_buffer();
      word_open = 1'b0;
      run_len   = '0;
      run_from  = '0;
      byte_pos  = '0;
      stopped   = 1'b0;
   endfunction

   // advance the model by one byte; queue the result it causes, if any
   function automatic void tokenize_byte(input logic [7:0] b, input logic last);
      result_type  r;
      class_type   cls;
      logic [15:0] at;
      logic [12:0] lim;
      logic        emit;
      logic        err;
      if (stopped) begin
         if (last) restart_buffer();
         return;
      end
      r    = '0;
      emit = 1'b0;
      err  = 1'b0;
      lim  = (max_word == 0 || max_word > MAX_WORD) ? 13'(MAX_WORD) : max_word;
      cls  = code_class(b);
      at   = byte_pos;
      byte_pos = byte_pos + 16'd1;
      case (cls)
         CLS_UNSET, CLS_FORBID: begin
            emit = 1'b1;
            err  = 1'b1;
            r.status      = (cls == CLS_UNSET) ? ST_INTERNAL : ST_FORBID;
            r.bad_char    = (cls == CLS_FORBID) ? b : 8'd0;
            r.word_start  = word_open ? run_from : at;
            r.word_length = word_open ? run_len : 13'd0;
            r.buffer_end  = last;
         end
         CLS_SEP: begin
            if (word_open) begin
               emit = 1'b1;
               r.word_start  = run_from;
               r.word_length = run_len;
               r.buffer_end  = last;
               if (min_word != 0 && run_len < min_word) begin
                  r.status = ST_SHORT;
                  err = 1'b1;
               end else begin
                  r.status = ST_WORD;
               end
               word_open = 1'b0;
               run_len   = '0;
            end else if (last) begin
               emit = 1'b1;
               r.status     = ST_DONE;
               r.buffer_end = 1'b1;
            end
         end
         default: begin
            if (!word_open) begin
               word_open = 1'b1;
               run_from  = at;
               run_len   = 13'd1;
            end else begin
               run_len = run_len + 13'd1;
            end
            if (run_len > lim) begin
               emit = 1'b1;
               err  = 1'b1;
               r.status      = ST_LONG;
               r.word_start  = run_from;
               r.word_length = run_len;
               r.buffer_end  = last;
            end else if (last) begin
               emit = 1'b1;
               r.status      = end_closes ? ST_WORD : ST_UNTERM;
               r.word_start  = run_from;
               r.word_length = run_len;
               r.buffer_end  = 1'b1;
            end
         end
      endcase
      if (emit) expected_results.insert(expected_results.size(), r);
      if (last) restart_buffer();
      else if (err) stopped = 1'b1;
   endfunction

   // ---------------- sender ----------------
   always @(negedge clock) begin
      if (byte_taken) void'(pending_bytes.pop_front());
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else if (!req_ch.valid || byte_taken) begin
         if (pending_bytes.size() == 0) begin
            req_ch.valid <= 1'b0;
         end else if (gap_left != 0) begin
            gap_left = gap_left - 1;
            req_ch.valid <= 1'b0;
         end else begin
            req_ch.valid      <= 1'b1;
            req_ch.byte_value <= pending_bytes[0].value;
            req_ch.last_byte  <= pending_bytes[0].last;
            burst_left = burst_left - 1;
            if (burst_left <= 0) begin
               // a quarter of the bursts run straight into the next one
               gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
               burst_left = $urandom_range(1, 24);
            end
         end
      end
   end

   // ---------------- receiver ----------------
   always @(negedge clock) begin
      rcv_cycle = rcv_cycle + 1;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left = hold_left - 1;
         rsp_ch.ready <= 1'b0;
      end else if (hold_asks != hold_served) begin
         hold_served = hold_served + 1;
         hold_left   = HOLD_CYCLES;
         rsp_ch.ready <= 1'b0;
      end else begin
         case (rcv_cycle[7:6])
            2'd0: rsp_ch.ready <= 1'b1;
            2'd1: rsp_ch.ready <= ($urandom_range(0, 9) < 7);
            2'd2: rsp_ch.ready <= (rcv_cycle[1:0] != 2'd0);
            default: rsp_ch.ready <= ($urandom_range(0, 9) < 3);
         endcase
      end
   end

   // ---------------- monitor / checker ----------------
   always @(posedge clock) begin
      byte_taken = !reset && req_ch.valid && req_ch.ready;
      if (byte_taken) begin
         tokenize_byte(req_ch.byte_value, req_ch.last_byte);
         bytes_seen = bytes_seen + 1;
      end
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         results_seen = results_seen + 1;
         got.word_start  = rsp_ch.word_start;
         got.word_length = rsp_ch.word_length;
         got.status      = status_type'(rsp_ch.status);
         got.bad_char    = rsp_ch.bad_char;
         got.buffer_end  = rsp_ch.buffer_end;
         if (expected_results.size() == 0) begin
            mismatches = mismatches + 1;
            $display("%0t: unexpected word: start %0d len %0d status %0d bad %02h end %0b",
                     $time, got.word_start, got.word_length, got.status, got.bad_char,
                     got.buffer_end);
         end else begin
            want = expected_results.pop_front();
            status_count[want.status] = status_count[want.status] + 1;
            if (got !== want) begin
               mismatches = mismatches + 1;
               $display("%0t: expected start %0d len %0d status %0d bad %02h end %0b",
                        $time, want.word_start, want.word_length, want.status,
                        want.bad_char, want.buffer_end);
               $display("%0t:   actual start %0d len %0d status %0d bad %02h end %0b",
                        $time, got.word_start, got.word_length, got.status,
                        got.bad_char, got.buffer_end);
            end
         end
      end
      if (byte_taken || (rsp_ch.valid && rsp_ch.ready)) idle_cycles = 0;
      else idle_cycles = idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("%0t: no progress for %0d cycles, %0d results outstanding",
                  $time, STALL_LIMIT, expected_results.size());
         $display("simulation failed");
         $finish;
      end
   end

   // ---------------- stimulus helpers ----------------
   function automatic void push_byte(input logic [7:0] b, input logic last);
      text_byte_type t;
      t.value = b;
      t.last  = last;
      pending_bytes.insert(pending_bytes.size(), t);
      bytes_queued = bytes_queued + 1;
   endfunction

   function automatic void push_text(input string s, input logic last_at_end);
      for (int i = 0; i < s.len(); i++)
         push_byte(s[i], last_at_end && (i == s.len() - 1));
   endfunction

   function automatic void set_class(input logic [7:0] code, input class_type c);
      plan_map[code[6:5]][2*code[4:0] +: 2] = c;
   endfunction

   // letters and digits form words, whitespace, comma and full stop split them, # @ ! $ are forbidden
   function automatic void text_map();
      for (int r = 0; r < 4; r++) plan_map[r] = '0;
      for (int c = 8'h61; c <= 8'h7A; c++) set_class(8'(c), CLS_ALLOW);
      for (int c = 8'h41; c <= 8'h5A; c++) set_class(8'(c), CLS_ALLOW);
      for (int c = 8'h30; c <= 8'h39; c++) set_class(8'(c), CLS_ALLOW);
      set_class(8'h20, CLS_SEP);
      set_class(8'h09, CLS_SEP);
      set_class(8'h0A, CLS_SEP);
      set_class(8'h2C, CLS_SEP);
      set_class(8'h2E, CLS_SEP);
      set_class(8'h23, CLS_FORBID);
      set_class(8'h40, CLS_FORBID);
      set_class(8'h21, CLS_FORBID);
      set_class(8'h24, CLS_FORBID);
   endfunction

   // random code of a given class in the current table, or any byte if none
   function automatic logic [7:0] pick_code(input class_type c);
      logic [7:0] b;
      for (int i = 0; i < 100; i++) begin
         b = 8'($urandom_range(0, 127));
         if (code_class(b) == c) return b;
      end
      return 8'($urandom_range(0, 255));
   endfunction

   task automatic write_reg(input csr_index_type idx, input logic [63:0] val);
      @(negedge clock);
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = val;
      @(negedge clock);
      csr_we = 1'b0;
      case (idx)
         CSR_MIN_LENGTH: min_word   = val[12:0];
         CSR_MAX_LENGTH: max_word   = val[12:0];
         CSR_ALLOW_END:  end_closes = val[0];
         default:        map_rows[idx[1:0]] = val;
      endcase
   endtask

   task automatic configure(input int min_len, input int max_len, input bit end_ok);
      for (int r = 0; r < 4; r++) write_reg(csr_index_type'(r), plan_map[r]);
      write_reg(CSR_MIN_LENGTH, 64'(min_len));
      write_reg(CSR_MAX_LENGTH, 64'(max_len));
      write_reg(CSR_ALLOW_END, 64'(end_ok));
   endtask

   // wait until every word has come back, then let the pipeline settle
   task automatic drain();
      while (pending_bytes.size() != 0 || expected_results.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // one buffer: mostly well-formed text, sometimes raw noise
   task automatic gen_buffer();
      int  lim, len_cap, n_words, len;
      bit  sep_end, last;
      logic [7:0] b;
      lim     = (max_word == 0 || max_word > MAX_WORD) ? MAX_WORD : max_word;
      len_cap = (lim > 10) ? 10 : lim + 1;
      if ($urandom_range(0, 9) < 8) begin
         repeat ($urandom_range(0, 2)) push_byte(pick_code(CLS_SEP), 1'b0);
         n_words = $urandom_range(1, 4);
         sep_end = 1'($urandom_range(0, 1));
         for (int w = 0; w < n_words; w++) begin
            len = $urandom_range(1, len_cap);
            for (int i = 0; i < len; i++) begin
               last = !sep_end && (w == n_words - 1) && (i == len - 1);
               if ($urandom_range(0, 39) == 0) b = 8'($urandom_range(0, 255));
               else b = pick_code(CLS_ALLOW);
               push_byte(b, last);
            end
            if (w < n_words - 1)
               repeat ($urandom_range(1, 2)) push_byte(pick_code(CLS_SEP), 1'b0);
         end
         if (sep_end) push_byte(pick_code(CLS_SEP), 1'b1);
      end else begin
         len = $urandom_range(1, 12);
         for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 1)) b = 8'($urandom_range(0, 255));
            else b = pick_code(class_type'($urandom_range(0, 3)));
            push_byte(b, i == len - 1);
         end
      end
   endtask

   // ---------------- test sequence ----------------
   initial begin
      int min_len, max_len, target;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // empty table after reset: everything is an internal error
      push_text("a", 1'b0);
      push_text("b", 1'b1);
      push_byte(8'hC8, 1'b1);
      drain();

      text_map();
      configure(2, 5, 1'b1);
      push_text("  ab x ", 1'b0);  // word, then too short
      push_text("q", 1'b1);        // halted: last byte only ends the halt
      push_text("abcdef", 1'b0);   // too long at the sixth byte
      push_text("z", 1'b1);
      push_text(" ", 1'b1);        // buffer done outside a word
      push_text("ab ", 1'b1);      // separator on the last byte
      push_text("abc", 1'b1);      // buffer end closes the word
      push_text("a#", 1'b0);       // forbidden byte inside a word
      push_text("x", 1'b1);
      push_text("#", 1'b1);        // forbidden byte on the last byte
      push_byte(8'hFF, 1'b1);      // code above the table
      push_text("a", 1'b0);
      push_byte(8'h00, 1'b0);      // unset code inside a word
      push_text("x", 1'b1);
      drain();

      configure(0, 1, 1'b0);
      push_text("a", 1'b1);        // unterminated end
      push_text("ab", 1'b1);       // too long on the last byte
      push_text(" a ", 1'b1);
      drain();

      configure(4096, 4096, 1'b1);
      push_text("ab ", 1'b1);      // every word too short
      drain();
      for (int r = 0; r < 4; r++) plan_map[r] = '1;
      configure(4096, 4096, 1'b0);
      push_byte(8'h7F, 1'b1);
      push_byte(8'h00, 1'b1);
      drain();

      // no explicit limit: a long word passes
      text_map();
      configure(0, 0, 1'b1);
      repeat (64) push_byte(8'h61, 1'b0);
      push_text(" ", 1'b1);
      drain();

      for (int p = 0; p < 6; p++) begin
         if (p % 3 == 2) begin
            for (int r = 0; r < 4; r++) plan_map[r] = {$urandom, $urandom};
         end else begin
            text_map();
            repeat (6) set_class(8'($urandom_range(0, 127)),
                                 class_type'($urandom_range(0, 3)));
         end
         min_len = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 4);
         case ($urandom_range(0, 3))
            0:       max_len = 0;
            1:       max_len = 4096;
            default: max_len = $urandom_range(1, 10);
         endcase
         configure(min_len, max_len, 1'($urandom_range(0, 1)));
         // long receiver stall while bytes keep coming
         if (p == 1) hold_asks = hold_asks + 1;
         target = bytes_queued + RANDOM_BYTES;
         while (bytes_queued < target) gen_buffer();
         drain();
      end

      $display("%0d bytes sent, %0d results checked: %0d words, %0d done, %0d errors",
               bytes_seen, results_seen, status_count[ST_WORD], status_count[ST_DONE],
               results_seen - status_count[ST_WORD] - status_count[ST_DONE]);
      if (mismatches == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
